// ===== design/mandelbrot_escape_time_assert.svh =====
// Assertion macros shared by the RTL.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MET_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mandelbrot_escape_time: same-cycle check failed");

// next-cycle implication
`define MET_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mandelbrot_escape_time: next-cycle check failed");

`endif

// ===== design/met_pkg.sv =====
`default_nettype none

package met_pkg;

	localparam int DEF_MAX_COLUMNS = 4096;
	localparam int DEF_MAX_ROWS    = 4096;
	localparam int DEF_COORD_WIDTH = 32;

	localparam int FRAC_BITS   = 28;
	localparam int COLOR_SHIFT = 20;

	localparam int IDX_W   = 12;
	localparam int CNT_W   = 16;
	localparam int COLOR_W = 28;
	localparam int EDGE_W  = 32;
	localparam int STEP_W  = 31;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int REG_W   = 3;

	localparam logic [REG_W-1:0] REG_LEFT   = 3'd0;
	localparam logic [REG_W-1:0] REG_BOTTOM = 3'd1;
	localparam logic [REG_W-1:0] REG_CSTEP  = 3'd2;
	localparam logic [REG_W-1:0] REG_RSTEP  = 3'd3;
	localparam logic [REG_W-1:0] REG_LIMIT  = 3'd4;

	localparam logic signed [EDGE_W-1:0] RST_LEFT   = -32'sd536870912;
	localparam logic signed [EDGE_W-1:0] RST_BOTTOM = -32'sd536870912;
	localparam logic [STEP_W-1:0]        RST_CSTEP  = 31'd2684355;
	localparam logic [STEP_W-1:0]        RST_RSTEP  = 31'd2684355;
	localparam logic [CNT_W-1:0]         RST_LIMIT  = 16'd10000;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MC   = 8'b0000_0010,
		S_MR   = 8'b0000_0100,
		S_CLD  = 8'b0000_1000,
		S_RR   = 8'b0001_0000,
		S_II   = 8'b0010_0000,
		S_RI   = 8'b0100_0000,
		S_CHK  = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// ===== design/met_if.sv =====
`default_nettype none

interface met_pix_if;
	import met_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] column_index;
	logic [IDX_W-1:0] row_index;

	modport source (output valid, output column_index, output row_index, input ready);
	modport sink   (input valid, input column_index, input row_index, output ready);
endinterface

interface met_res_if;
	import met_pkg::*;

	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   iteration_count;
	logic               escaped;
	logic [COLOR_W-1:0] color_word;

	modport source (output valid, output iteration_count, output escaped, output color_word,
		input ready);
	modport sink   (input valid, input iteration_count, input escaped, input color_word,
		output ready);
endinterface

`default_nettype wire

// ===== design/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time engine, one pixel at a time.
// pix (valid/ready): a beat carries column_index and row_index. The pixel maps to
// c = left_edge + col*column_step + i*(bottom_edge + row*row_step) in Q4.28, and
// z = z*z + c runs from zero until |z|^2 >= 4.0 or iteration_limit is reached.
// res (valid/ready): one beat per pixel with iteration_count, escaped, color_word.
// APB port: left_edge 0x00, bottom_edge 0x04, column_step 0x08, row_step 0x0C,
// iteration_limit 0x10; pready tied high; write only while idle.
// Datapath: a single registered multiplier does every product, so an iteration is
// three products plus update/test (states S_RR, S_II, S_RI, S_CHK). pix.ready
// rises in the same cycle as res.valid for the finished pixel, and a new pixel is
// taken only after the current one is through.
// The result sits in an output register, so the next pixel is taken while res
// stalls; a second result then waits in its final state until res drains.
// Reset (arst_n low) restores register defaults and drops any pixel in flight.
`default_nettype none
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time #(
	parameter int MAX_COLUMNS = met_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = met_pkg::DEF_MAX_ROWS,
	parameter int COORD_WIDTH = met_pkg::DEF_COORD_WIDTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	met_pix_if.sink                     pix,
	met_res_if.source                   res,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [met_pkg::ADDR_W-1:0]  paddr,
	input  wire  [met_pkg::DATA_W-1:0]  pwdata,
	output logic [met_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import met_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int MW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 2;
	localparam int LW = 17;

	localparam logic signed [SW-1:0] CMAX = SW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [SW-1:0] CMIN = ~CMAX;
	localparam logic signed [SW-1:0] ESC_BOUND = SW'(1) <<< (FRAC_BITS + 2);
	localparam logic [LW-1:0] COL_LAST = LW'(MAX_COLUMNS - 1);
	localparam logic [LW-1:0] ROW_LAST = LW'(MAX_ROWS - 1);

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > CMAX) r = CMAX[CW-1:0];
		else if (v < CMIN) r = CMIN[CW-1:0];
		else r = v[CW-1:0];
		return r;
	endfunction

	// configuration
	logic signed [EDGE_W-1:0] left_q, bottom_q;
	logic [STEP_W-1:0]        cstep_q, rstep_q;
	logic [CNT_W-1:0]         limit_q;
	logic [REG_W-1:0]         reg_idx;
	logic                     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= RST_LEFT;
			bottom_q <= RST_BOTTOM;
			cstep_q  <= RST_CSTEP;
			rstep_q  <= RST_RSTEP;
			limit_q  <= RST_LIMIT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LEFT:   left_q   <= pwdata;
				REG_BOTTOM: bottom_q <= pwdata;
				REG_CSTEP:  cstep_q  <= pwdata[STEP_W-1:0];
				REG_RSTEP:  rstep_q  <= pwdata[STEP_W-1:0];
				REG_LIMIT:  limit_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEFT:   prdata = left_q;
			REG_BOTTOM: prdata = bottom_q;
			REG_CSTEP:  prdata = {1'b0, cstep_q};
			REG_RSTEP:  prdata = {1'b0, rstep_q};
			REG_LIMIT:  prdata = {{(DATA_W-CNT_W){1'b0}}, limit_q};
			default:    prdata = '0;
		endcase
	end

	// datapath
	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       col_q, row_q;
	logic [CNT_W-1:0]       lim_q, count_q;
	logic signed [CW-1:0]   c_re_q, c_im_q, zr_q, zi_q, rr_q, ii_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [MW-1:0]   mul_a, mul_b;
	logic                   res_valid_q, res_esc_q;
	logic [CNT_W-1:0]       res_count_q;

	logic pix_acc, done, out_free, escape;
	logic signed [CW-1:0] mag, dif, nr, ri, ni, prod_rr;

	assign pix.ready = (state_q == S_IDLE);
	assign pix_acc   = pix.valid && pix.ready;
	assign out_free  = !res_valid_q || res.ready;

	assign prod_rr = sat_cw(SW'(prod_q >>> FRAC_BITS));
	assign mag     = sat_cw(SW'(rr_q) + SW'(ii_q));
	assign dif     = sat_cw(SW'(rr_q) - SW'(ii_q));
	assign nr      = sat_cw(SW'(dif) + SW'(c_re_q));
	assign ri      = sat_cw(SW'(prod_q >>> (FRAC_BITS - 1)));
	assign ni      = sat_cw(SW'(ri) + SW'(c_im_q));
	assign escape  = (SW'(mag) >= ESC_BOUND);
	assign done    = escape || (count_q == lim_q);

	always_comb begin
		case (state_q)
			S_MC: begin
				mul_a = MW'({1'b0, col_q});
				mul_b = MW'({1'b0, cstep_q});
			end
			S_MR: begin
				mul_a = MW'({1'b0, row_q});
				mul_b = MW'({1'b0, rstep_q});
			end
			S_II: begin
				mul_a = MW'(zi_q);
				mul_b = MW'(zi_q);
			end
			S_RI: begin
				mul_a = MW'(zr_q);
				mul_b = MW'(zi_q);
			end
			default: begin
				mul_a = MW'(zr_q);
				mul_b = MW'(zr_q);
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (pix_acc) state_d = S_MC;
			S_MC:   state_d = S_MR;
			S_MR:   state_d = S_CLD;
			S_CLD:  state_d = S_II;
			S_RR:   state_d = S_II;
			S_II:   state_d = S_RI;
			S_RI:   state_d = S_CHK;
			S_CHK: begin
				if (!done) state_d = S_RR;
				else if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pix_acc) count_q <= '0;
			else if (state_q == S_CHK && !done) count_q <= count_q + 1'b1;
			if (state_q == S_CHK && done && out_free) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: if (pix_acc) begin
				col_q <= (LW'(pix.column_index) > COL_LAST) ? COL_LAST[IDX_W-1:0]
					: pix.column_index;
				row_q <= (LW'(pix.row_index) > ROW_LAST) ? ROW_LAST[IDX_W-1:0]
					: pix.row_index;
				lim_q <= (limit_q == '0) ? CNT_W'(1) : limit_q;
				zr_q  <= '0;
				zi_q  <= '0;
			end
			S_MR:  c_re_q <= sat_cw(SW'(left_q) + SW'(prod_q));
			S_CLD: c_im_q <= sat_cw(SW'(bottom_q) + SW'(prod_q));
			S_II:  rr_q   <= prod_rr;
			S_RI:  ii_q   <= prod_rr;
			S_CHK: begin
				if (!done) begin
					zr_q <= nr;
					zi_q <= ni;
				end else if (out_free) begin
					res_count_q <= count_q;
					res_esc_q   <= escape;
				end
			end
			default: ;
		endcase
	end

	assign res.valid           = res_valid_q;
	assign res.iteration_count = res_count_q;
	assign res.escaped         = res_esc_q;
	assign res.color_word      = COLOR_W'({res_count_q[7:0], {COLOR_SHIFT{1'b0}}});

	`MET_ASSERT_NXT(a_accept_starts, pix.valid && pix.ready, state_q == S_MC)
	`MET_ASSERT_IMP(a_count_in_limit, state_q != S_IDLE, count_q <= lim_q)
	`MET_ASSERT_IMP(a_count_nonzero, res_valid_q, res_count_q != '0)

endmodule

`default_nettype wire

// ===== dv/tb_mandelbrot_escape_time.sv =====
`default_nettype none

module tb_mandelbrot_escape_time;
	timeunit 1ns;
	timeprecision 1ps;

	import met_pkg::*;

	localparam int     CYCLE_LIMIT  = 8_000_000;
	localparam int     ITEMS_PER_RANDOM_PHASE = 25;
	localparam int     RANDOM_PHASES = 4;
	localparam int     STALL_CYCLES = 400;
	localparam longint COORD_MAX    = (64'sd1 <<< (DEF_COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN    = -COORD_MAX - 1;
	localparam longint ESCAPE_BOUND = 64'sd4 <<< FRAC_BITS;

	localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic               escaped;
		logic [COLOR_W-1:0] color;
	} pixel_result_t;

	class pixel_escape_book;
		longint        re_origin;
		longint        im_origin;
		longint        re_step;
		longint        im_step;
		int unsigned   iter_cap;
		pixel_result_t awaited_results[$];
		int            failures;

		function new();
			re_origin = longint'(RST_LEFT);
			im_origin = longint'(RST_BOTTOM);
			re_step   = longint'(RST_CSTEP);
			im_step   = longint'(RST_RSTEP);
			iter_cap  = RST_LIMIT;
			failures  = 0;
		endfunction

		function void set_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_LEFT:   re_origin = longint'($signed(value));
				REG_BOTTOM: im_origin = longint'($signed(value));
				REG_CSTEP:  re_step   = longint'(value[STEP_W-1:0]);
				REG_RSTEP:  im_step   = longint'(value[STEP_W-1:0]);
				REG_LIMIT:  iter_cap  = value[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > COORD_MAX) return COORD_MAX;
			if (v < COORD_MIN) return COORD_MIN;
			return v;
		endfunction

		function longint qmul(longint a, longint b, int shift);
			return sat((a * b) >>> shift);
		endfunction

		function pixel_result_t escape_of(logic [IDX_W-1:0] column, logic [IDX_W-1:0] row);
			pixel_result_t r;
			longint col_n, row_n, c_re, c_im, zr, zi, mag, nr, ni;
			int unsigned cap, cnt;
			col_n = longint'(column);
			row_n = longint'(row);
			if (col_n >= DEF_MAX_COLUMNS) col_n = DEF_MAX_COLUMNS - 1;
			if (row_n >= DEF_MAX_ROWS) row_n = DEF_MAX_ROWS - 1;
			cap = (iter_cap == 0) ? 1 : iter_cap;
			c_re = sat(re_origin + col_n * re_step);
			c_im = sat(im_origin + row_n * im_step);
			zr = 0;
			zi = 0;
			mag = 0;
			cnt = 0;
			while (cnt < cap && mag < ESCAPE_BOUND) begin
				nr = sat(sat(qmul(zr, zr, FRAC_BITS) - qmul(zi, zi, FRAC_BITS)) + c_re);
				ni = sat(qmul(zr, zi, FRAC_BITS - 1) + c_im);
				zr = nr;
				zi = ni;
				mag = sat(qmul(zr, zr, FRAC_BITS) + qmul(zi, zi, FRAC_BITS));
				cnt++;
			end
			r.count   = cnt[CNT_W-1:0];
			r.escaped = (mag >= ESCAPE_BOUND);
			r.color   = COLOR_W'(cnt[7:0]) << COLOR_SHIFT;
			return r;
		endfunction

		function void log_pixel(logic [IDX_W-1:0] column, logic [IDX_W-1:0] row);
			awaited_results.push_back(escape_of(column, row));
		endfunction

		function void report_mismatch(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			failures++;
		endfunction

		function void check_pixel_result(pixel_result_t got);
			pixel_result_t want;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result beat, count", got.count, 0);
				return;
			end
			want = awaited_results.pop_front();
			if (got.count !== want.count)
				report_mismatch("iteration_count", got.count, want.count);
			if (got.escaped !== want.escaped)
				report_mismatch("escaped", got.escaped, want.escaped);
			if (got.color !== want.color)
				report_mismatch("color_word", got.color, want.color);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	wire  [DATA_W-1:0]  prdata;
	wire                pready;

	met_pix_if pix_bus ();
	met_res_if res_bus ();

	pixel_escape_book book;
	bit  quiet;
	int  hold_left;
	int  cycle_count = 0;

	mandelbrot_escape_time dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: a long hold-off while one is pending, otherwise random back-pressure (always ready when quiet)
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				res_bus.ready <= (quiet || $urandom_range(0, 99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready)
			book.check_pixel_result({res_bus.iteration_count, res_bus.escaped,
				res_bus.color_word});
	end

	task automatic send_pixel(input logic [IDX_W-1:0] column, input logic [IDX_W-1:0] row);
		while (!quiet && $urandom_range(0, 99) < 35) begin
			@(negedge clk);
			pix_bus.valid <= 1'b0;
		end
		@(negedge clk);
		pix_bus.valid        <= 1'b1;
		pix_bus.column_index <= column;
		pix_bus.row_index    <= row;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
		book.log_pixel(column, row);
	endtask

	task automatic end_burst();
		@(negedge clk);
		pix_bus.valid <= 1'b0;
		while (book.awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		book.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_regs(input logic [DATA_W-1:0] left, input logic [DATA_W-1:0] bottom,
		input logic [DATA_W-1:0] cstep, input logic [DATA_W-1:0] rstep,
		input logic [DATA_W-1:0] limit);
		apb_write(REG_LEFT, left);
		apb_write(REG_BOTTOM, bottom);
		apb_write(REG_CSTEP, cstep);
		apb_write(REG_RSTEP, rstep);
		apb_write(REG_LIMIT, limit);
	endtask

	// window origin in roughly [-2.5, 0.5] x [-1.5, 1.5]
	task automatic program_near_set(input int unsigned cap);
		program_regs(32'(int'($urandom_range(0, 805306368)) - 671088640),
			32'(int'($urandom_range(0, 805306368)) - 402653184),
			{1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0004_0000))},
			{1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0004_0000))},
			{16'($urandom), 16'(cap)});
	endtask

	initial begin : stimulus
		pixel_result_t probe;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		pix_bus.valid        = 1'b0;
		pix_bus.column_index = '0;
		pix_bus.row_index    = '0;
		quiet                = 1'b0;
		hold_left            = 0;
		book                 = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window: corners, saturated far corner, one point deep inside the set
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd200, 12'd200);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		end_burst();

		// extreme edges and steps, zero limit behaves as one, spare addresses ignored
		program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'hFFFF_0000);
		apb_write(REG_SPARE_LO, 32'h1234_5678);
		apb_write(REG_SPARE_HI, 32'hFFFF_FFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd0, 12'd1);
		send_pixel(12'd4095, 12'd0);
		end_burst();

		// full limit: origin never escapes, far corner escapes at once
		program_regs(32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000,
			32'h0000_FFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		end_burst();

		// c = 0.26 escapes slowly; set the limit to land on that exact iteration
		program_regs(32'd69793218, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_FFFF);
		probe = book.escape_of(12'd0, 12'd0);
		if (probe.escaped)
			apb_write(REG_LIMIT, DATA_W'(probe.count));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		end_burst();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					quiet = 1'b1;
					program_near_set($urandom_range(1, 256));
				end
				1: begin
					program_near_set($urandom_range(1, 4));
					hold_left = STALL_CYCLES;
				end
				2: program_regs($urandom, $urandom, $urandom, $urandom,
					{16'($urandom), 16'($urandom_range(0, 300))});
				default: program_near_set($urandom_range(1, 256));
			endcase
			for (int n = 0; n < ITEMS_PER_RANDOM_PHASE; n++)
				send_pixel(IDX_W'($urandom), IDX_W'($urandom));
			end_burst();
			quiet = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (book.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
